// ----- rtl/frame_slot_pool_manager_defines.svh -----
// Assertion macros shared by the frame slot pool manager RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FRAME_SLOT_POOL_MANAGER_DEFINES_SVH
`define FRAME_SLOT_POOL_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define FSPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fspm assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define FSPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fspm assertion failed");
`else
`define FSPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/fspm_pkg.sv -----
// Types and constants for the frame slot pool manager.
// No dependencies; imported by every module of the block.
package fspm_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int RDR_W      = 8;
    localparam int TAG_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [RDR_W-1:0] RDR_MAX      = 8'hFF;
    localparam logic [TAG_W-1:0] TAG_RESET    = 32'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQ_WR  = 2'd0,
        CMD_PUBLISH = 2'd1,
        CMD_ACQ_RD  = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_STALE     = 3'd4,
        ST_LIMIT     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_FREE    = 2'd0,
        PH_WRITING = 2'd1,
        PH_READY   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MOD  = 3'd1,
        S_SCAN = 3'd2,
        S_EXEC = 3'd3,
        S_DONE = 3'd4
    } t_state;

    // One slot entry
    typedef struct packed {
        t_phase            phase;
        logic [RDR_W-1:0]  count;
        logic [TAG_W-1:0]  tag;
    } t_slot;

    // Slot store write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        t_slot             data;
    } t_slot_wr;

endpackage

// ----- rtl/fspm_slot_store.sv -----
// Slot state store: phase, reader count and generation tag per slot.
// Depends on fspm_pkg; one read port and one write port.
module fspm_slot_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fspm_pkg::IDX_W-1:0] i_rd_addr,
    input  fspm_pkg::t_slot_wr         i_wr,
    output fspm_pkg::t_slot            o_rd
);
    import fspm_pkg::*;

    t_slot r_slot [SLOTS];

    // Reset to free, zero readers, tag one; single write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i].phase <= PH_FREE;
                r_slot[i].count <= '0;
                r_slot[i].tag   <= TAG_RESET;
            end
        end else if (i_wr.en) begin
            r_slot[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port
    assign o_rd = r_slot[i_rd_addr];

endmodule

// ----- rtl/fspm_seq.sv -----
// Command sequencer with a shared 5-bit compare/subtract unit and result register.
// Depends on fspm_pkg and frame_slot_pool_manager_defines.svh; drives fspm_slot_store.
`include "frame_slot_pool_manager_defines.svh"
module fspm_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fspm_pkg::CNT_W-1:0]  i_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fspm_pkg::CMD_W-1:0]  i_cmd,
    input  logic [fspm_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [fspm_pkg::TAG_W-1:0]  i_expected_generation,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fspm_pkg::STAT_W-1:0] o_status,
    output logic [fspm_pkg::IDX_W-1:0]  o_granted_slot,
    output logic [fspm_pkg::TAG_W-1:0]  o_generation,
    output logic [fspm_pkg::IDX_W-1:0]  o_rd_addr,
    input  fspm_pkg::t_slot             i_rd,
    output fspm_pkg::t_slot_wr          o_wr
);
    import fspm_pkg::*;

    t_state           r_state,  n_state;
    t_cmd             r_cmd,    n_cmd;
    logic [IDX_W-1:0] r_idx,    n_idx;
    logic [TAG_W-1:0] r_expect, n_expect;
    logic [IDX_W-1:0] r_ptr,    n_ptr;
    logic [CNT_W-1:0] r_k,      n_k;
    logic [IDX_W-1:0] r_search, n_search;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_slot,   n_res_slot;
    logic [TAG_W-1:0] r_res_gen,    n_res_gen;
    logic             r_out_valid,  n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_slot,   n_out_slot;
    logic [TAG_W-1:0] r_out_gen,    n_out_gen;

    logic             w_accept;
    t_cmd             w_in_cmd;
    logic             w_in_bad;
    logic [CNT_W-1:0] w_ptr_ext;
    logic [CNT_W-1:0] w_unit_sum;
    logic             w_ptr_ge_n;
    logic             w_hit;
    logic [CNT_W-1:0] w_k_inc;
    logic             w_last;
    logic             w_load;

    // Shared unit: subtract n while reducing, add one while scanning
    assign w_ptr_ext  = {1'b0, r_ptr};
    assign w_ptr_ge_n = (w_ptr_ext >= i_n);
    assign w_unit_sum = (r_state == S_MOD) ? (w_ptr_ext - i_n) : (w_ptr_ext + 5'd1);

    // Decode and scan flags
    assign w_accept = i_in_valid && o_in_ready;
    assign w_in_cmd = t_cmd'(i_cmd);
    assign w_in_bad = ({1'b0, i_slot_index} >= i_n);
    assign w_hit    = (i_rd.phase == PH_FREE) && (i_rd.count == '0);
    assign w_k_inc  = r_k + 5'd1;
    assign w_last   = (w_k_inc == i_n);
    assign w_load   = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_cmd == CMD_ACQ_WR) begin
                        n_state = (i_n == '0) ? S_DONE : S_MOD;
                    end else begin
                        n_state = w_in_bad ? S_DONE : S_EXEC;
                    end
                end
            end
            S_MOD: begin
                if (!w_ptr_ge_n) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit || w_last) n_state = S_DONE;
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_expect     = r_expect;
        n_ptr        = r_ptr;
        n_k          = r_k;
        n_search     = r_search;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_gen    = r_res_gen;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_gen    = r_out_gen;
        o_wr         = '0;
        o_rd_addr    = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = w_in_cmd;
                    n_idx    = i_slot_index;
                    n_expect = i_expected_generation;
                    n_k      = '0;
                    if (w_in_cmd == CMD_ACQ_WR) begin
                        n_res_status = ST_NO_FREE;
                        n_res_slot   = '0;
                        n_res_gen    = '0;
                        if (i_n != '0) begin
                            n_ptr    = r_search;
                            n_search = r_search + 4'd1;
                        end
                    end else if (w_in_bad) begin
                        n_res_status = ST_BAD_INDEX;
                        n_res_slot   = i_slot_index;
                        n_res_gen    = '0;
                    end else begin
                        n_ptr = i_slot_index;
                    end
                end
            end
            S_MOD: begin
                // start pointer modulo n by repeated subtraction
                if (w_ptr_ge_n) n_ptr = w_unit_sum[IDX_W-1:0];
            end
            S_SCAN: begin
                if (w_hit) begin
                    o_wr.en         = 1'b1;
                    o_wr.addr       = r_ptr;
                    o_wr.data.phase = PH_WRITING;
                    o_wr.data.count = 8'd1;
                    o_wr.data.tag   = i_rd.tag;
                    n_res_status    = ST_OK;
                    n_res_slot      = r_ptr;
                    n_res_gen       = i_rd.tag;
                end else begin
                    n_k = w_k_inc;
                    // wrap at the active count
                    n_ptr = (w_unit_sum == i_n) ? '0 : w_unit_sum[IDX_W-1:0];
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_slot   = r_idx;
                n_res_gen    = i_rd.tag;
                o_wr.addr    = r_ptr;
                o_wr.data    = i_rd;
                case (r_cmd)
                    CMD_PUBLISH: begin
                        o_wr.en         = 1'b1;
                        o_wr.data.phase = PH_READY;
                        o_wr.data.count = '0;
                        o_wr.data.tag   = i_rd.tag + 32'd1;
                        n_res_gen       = i_rd.tag + 32'd1;
                    end
                    CMD_ACQ_RD: begin
                        if (i_rd.phase != PH_READY) begin
                            n_res_status = ST_NOT_READY;
                        end else if (i_rd.tag != r_expect) begin
                            n_res_status = ST_STALE;
                        end else if (i_rd.count == RDR_MAX) begin
                            n_res_status = ST_LIMIT;
                        end else begin
                            o_wr.en         = 1'b1;
                            o_wr.data.count = i_rd.count + 8'd1;
                        end
                    end
                    CMD_RELEASE: begin
                        if (i_rd.count == '0) begin
                            n_res_status = ST_LIMIT;
                        end else begin
                            o_wr.en         = 1'b1;
                            o_wr.data.count = i_rd.count - 8'd1;
                            if (i_rd.count == 8'd1) o_wr.data.phase = PH_FREE;
                        end
                    end
                    default: n_res_status = ST_OK;
                endcase
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_gen    = r_res_gen;
                end
            end
            default: n_out_valid = r_out_valid && !i_out_ready;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_search    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_search    <= n_search;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_expect     <= n_expect;
        r_ptr        <= n_ptr;
        r_k          <= n_k;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_gen    <= n_res_gen;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_gen    <= n_out_gen;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_generation   = r_out_gen;

    // Store writes only from the scan and execute steps
    `FSPM_ASSERT_IMP(a_wr_state, i_clk, i_rst_n, o_wr.en, (r_state == S_SCAN || r_state == S_EXEC))
    // Scan pointer stays inside the active range
    `FSPM_ASSERT_IMP(a_scan_ptr, i_clk, i_rst_n, (r_state == S_SCAN), (w_ptr_ext < i_n))
    // Scan never runs past n probes
    `FSPM_ASSERT_IMP(a_scan_k, i_clk, i_rst_n, (r_state == S_SCAN), (r_k < i_n))
    // A write grant only lands on a free, unread slot
    `FSPM_ASSERT_IMP(a_grant_free, i_clk, i_rst_n, (o_wr.en && r_state == S_SCAN), w_hit)
    // Finishing a command always presents a result
    `FSPM_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, (r_state == S_DONE && w_load), r_out_valid)

endmodule

// ----- rtl/frame_slot_pool_manager.sv -----
// Frame slot pool manager top level: config register, sequencer and slot store.
// Depends on fspm_pkg, fspm_slot_store and fspm_seq.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_cmd, i_slot_index, i_expected_generation
//  out     | output    | o_out_valid/i_out_ready | o_status, o_granted_slot, o_generation
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_active_slots
//
// Publish, acquire read and release step through accept, store read-modify-write and finish;
// a bad index, or acquire write on an empty pool, goes from accept straight to finish.
// Acquire write steps through accept, the mod n subtractions (up to 15), the probes (up to n) and finish.
// The result register frees the input side: a new item is accepted while a result waits.
// Synchronous reset clears all slots to free, zero readers, tag one; active_slots resets to 16.
// A stalled output holds the finished command in its last step until the register frees.
module frame_slot_pool_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fspm_pkg::CMD_W-1:0]  i_cmd,
    input  logic [fspm_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [fspm_pkg::TAG_W-1:0]  i_expected_generation,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fspm_pkg::STAT_W-1:0] o_status,
    output logic [fspm_pkg::IDX_W-1:0]  o_granted_slot,
    output logic [fspm_pkg::TAG_W-1:0]  o_generation,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fspm_pkg::CNT_W-1:0]  i_cfg_active_slots
);
    import fspm_pkg::*;

    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] w_n;
    logic [IDX_W-1:0] w_rd_addr;
    t_slot            w_rd;
    t_slot_wr         w_wr;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_active_slots;
        end
    end

    // Effective slot count saturates at the pool size
    assign w_n = (r_active > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : r_active;

    fspm_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .o_rd      (w_rd)
    );

    fspm_seq u_seq (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_n                   (w_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_cmd                 (i_cmd),
        .i_slot_index          (i_slot_index),
        .i_expected_generation (i_expected_generation),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_status              (o_status),
        .o_granted_slot        (o_granted_slot),
        .o_generation          (o_generation),
        .o_rd_addr             (w_rd_addr),
        .i_rd                  (w_rd),
        .o_wr                  (w_wr)
    );

endmodule
